>>> rtl/core/bce_pkg.sv
package bce_pkg;

    localparam int CoordW = 32;
    localparam int TW     = 16;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_EVALUATE = 2'd1,
        OP_SUBDIV   = 2'd2,
        OP_ELEVATE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD_T = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE_RD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_ALU_GO,
        S_ALU_WAIT,
        S_WR,
        S_EMIT,
        S_TAIL_RD,
        S_TAIL_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_OUT
    } t_state;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        logic   start;
        logic   is_div;
        t_coord p;
        t_coord q;
        logic [TW-1:0] t;
        logic [6:0] wi;
        logic [6:0] wn;
    } t_alu_req;

endpackage

>>> rtl/core/bezier_curve_engine_core.sv
// Bezier curve engine. Load points with op 0 (final_point sets the count),
// then evaluate (1), subdivide (2) or elevate (3). All curve work runs on one
// shared per-axis unit under a sequencer and the block is not ready while
// busy. Each interpolated point takes three reads, the three axes in turn
// through the unit and one write; subdivide adds one read and an emit per
// emitted point plus any output stall; elevate runs each inner point through
// a 41-bit divider retiring one bit per cycle, then copies the points back.
// Loads are written in the idle state.
module bezier_curve_engine_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: point_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
    //        param_t[115:100], zero fill [119:116]
    input  logic [119:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]    s_axis_tuser,
    input  logic          s_axis_tlast,   // final_point
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]    m_axis_tuser,
    output logic          m_axis_tlast    // last_of_run
);
    import bce_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_point  r_ctl [MAX_POINTS];
    t_point  r_wrk [MAX_POINTS];
    t_point  r_rd;

    t_state  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [1:0]    r_ax, n_ax;
    t_op           r_op, n_op;
    logic [TW-1:0] r_t, n_t;
    t_point        r_a, n_a;
    t_point        r_b, n_b;
    t_point        r_acc, n_acc;
    t_point        r_first, n_first;
    t_status       r_pst, n_pst;
    logic          r_plast, n_plast;
    t_state        r_ret, n_ret;
    logic          r_ov, n_ov;
    t_point        r_od, n_od;
    t_status       r_ost, n_ost;
    logic          r_olast, n_olast;

    logic          w_rd_ctl;
    logic [IW-1:0] w_rd_addr;
    logic          w_wr_ctl;
    logic [IW-1:0] w_ctl_addr;
    t_point        w_ctl_data;
    logic          w_wr_wrk;
    logic [IW-1:0] w_wrk_addr;
    t_alu_req      w_req;
    logic          w_done;
    t_coord        w_res;
    t_coord        w_pa, w_pb;

    t_op           w_in_op;
    logic [3:0]    w_in_idx;
    logic [TW-1:0] w_in_t;
    logic          w_acc;
    logic          w_out_free;
    logic          w_lvl_end;
    logic          w_last_lvl;
    logic          w_is_elev;

    assign w_in_op  = t_op'(s_axis_tuser);
    assign w_in_idx = s_axis_tdata[3:0];
    assign w_in_t   = s_axis_tdata[115:100];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc    = s_axis_tvalid && s_axis_tready;

    assign w_out_free = !r_ov || m_axis_tready;
    assign w_lvl_end  = (r_j + 1'b1 == r_n - r_i);
    assign w_last_lvl = (r_i + 1'b1 == r_n);
    assign w_is_elev  = (r_op == OP_ELEVATE);

    bce_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Memories: one read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd <= w_rd_ctl ? r_ctl[w_rd_addr] : r_wrk[w_rd_addr];
        if (w_wr_ctl) r_ctl[w_ctl_addr] <= w_ctl_data;
        if (w_wr_wrk) r_wrk[w_wrk_addr] <= r_acc;
    end

    always_comb begin
        case (r_ax)
            2'd1:    begin w_pa = r_a.y; w_pb = r_b.y; end
            2'd2:    begin w_pa = r_a.z; w_pb = r_b.z; end
            default: begin w_pa = r_a.x; w_pb = r_b.x; end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_in_op != OP_LOAD) begin
                    if (r_cnt == '0) n_state = S_OUT;
                    else if (w_in_op == OP_SUBDIV && w_in_t == '0) n_state = S_OUT;
                    else if (w_in_op == OP_ELEVATE) begin
                        if (r_cnt >= CW'(MAX_POINTS)) n_state = S_OUT;
                        else if (r_cnt == CW'(1)) n_state = S_TAIL_RD;
                        else n_state = S_RD0;
                    end else if (w_in_op == OP_SUBDIV || r_cnt == CW'(1))
                        n_state = S_SINGLE_RD;
                    else n_state = S_RD0;
                end
            end
            S_SINGLE_RD: n_state = S_EMIT;
            S_RD0:       n_state = S_RD1;
            S_RD1:       n_state = S_RD2;
            S_RD2:       n_state = S_ALU_GO;
            S_ALU_GO:    n_state = S_ALU_WAIT;
            S_ALU_WAIT:  if (w_done) n_state = (r_ax == 2'd2) ? S_WR : S_ALU_GO;
            S_WR: begin
                if (w_is_elev) n_state = w_last_lvl ? S_TAIL_RD : S_RD0;
                else if (!w_lvl_end) n_state = S_RD0;
                else if (r_op == OP_SUBDIV) n_state = S_EMIT;
                else n_state = w_last_lvl ? S_EMIT : S_RD0;
            end
            S_EMIT:      if (w_out_free) n_state = r_ret;
            S_TAIL_RD:   n_state = S_TAIL_WR;
            S_TAIL_WR:   n_state = (r_n == CW'(1)) ? S_OUT : S_COPY_RD;
            S_COPY_RD:   n_state = S_COPY_WR;
            S_COPY_WR:   n_state = (r_j == r_n - 1'b1) ? S_OUT : S_COPY_RD;
            S_OUT:       if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath control.
    always_comb begin
        n_cnt = r_cnt; n_n = r_n; n_i = r_i; n_j = r_j; n_ax = r_ax; n_op = r_op;
        n_t = r_t; n_a = r_a; n_b = r_b; n_acc = r_acc; n_first = r_first;
        n_pst = r_pst; n_plast = r_plast; n_ret = r_ret;
        n_ov = r_ov; n_od = r_od; n_ost = r_ost; n_olast = r_olast;
        w_rd_ctl = 1'b0; w_rd_addr = '0;
        w_wr_ctl = 1'b0; w_ctl_addr = '0; w_ctl_data = r_acc;
        w_wr_wrk = 1'b0; w_wrk_addr = '0;
        w_req = '0;
        w_req.t = r_t; w_req.p = w_pa; w_req.q = w_pb;
        w_req.wi = 7'(r_i); w_req.wn = 7'(r_n);
        w_req.is_div = w_is_elev;
        // drop the result once taken
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_op = w_in_op; n_t = w_in_t; n_n = r_cnt;
                n_i = CW'(1); n_j = '0; n_ax = '0;
                n_pst = ST_OK; n_plast = 1'b1; n_ret = S_IDLE;
                if (w_acc && w_in_op == OP_LOAD && 32'(w_in_idx) < MAX_POINTS) begin
                    w_wr_ctl   = 1'b1;
                    w_ctl_addr = IW'(w_in_idx);
                    w_ctl_data = s_axis_tdata[99:4];
                    if (s_axis_tlast) n_cnt = CW'(w_in_idx) + 1'b1;
                end
                if (w_acc && w_in_op != OP_LOAD) begin
                    if (r_cnt == '0) n_pst = ST_EMPTY;
                    else if (w_in_op == OP_SUBDIV && w_in_t == '0) n_pst = ST_BAD_T;
                    else if (w_in_op == OP_ELEVATE && r_cnt >= CW'(MAX_POINTS))
                        n_pst = ST_FULL;
                    else if (w_in_op != OP_ELEVATE) begin
                        // fetch the last point: first subdivide item or a lone point
                        w_rd_ctl  = 1'b1;
                        w_rd_addr = IW'(r_cnt - 1'b1);
                        n_plast   = (r_cnt == CW'(1));
                        n_ret     = (r_cnt == CW'(1)) ? S_IDLE : S_RD0;
                    end
                end
            end
            S_SINGLE_RD: begin
                n_acc = r_rd;
            end
            S_RD0: begin
                w_rd_ctl  = w_is_elev || (r_i == CW'(1));
                w_rd_addr = w_is_elev ? IW'(r_i - 1'b1) : IW'(r_j);
            end
            S_RD1: begin
                w_rd_ctl  = w_is_elev || (r_i == CW'(1));
                w_rd_addr = w_is_elev ? IW'(r_i) : IW'(r_j + 1'b1);
                n_a = r_rd;
            end
            S_RD2: begin
                n_b = r_rd;
            end
            S_ALU_GO: begin
                w_req.start = 1'b1;
            end
            S_ALU_WAIT: begin
                if (w_done) begin
                    case (r_ax)
                        2'd0:    n_acc.x = w_res;
                        2'd1:    n_acc.y = w_res;
                        default: n_acc.z = w_res;
                    endcase
                    n_ax = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
            end
            S_WR: begin
                w_wr_wrk   = 1'b1;
                w_wrk_addr = w_is_elev ? IW'(r_i) : IW'(r_j);
                if (w_is_elev) begin
                    n_i = r_i + 1'b1;
                end else begin
                    if (r_j == '0) n_first = r_acc;
                    if (!w_lvl_end) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                        n_plast = w_last_lvl;
                        n_ret = w_last_lvl ? S_IDLE : S_RD0;
                        if (r_op == OP_SUBDIV) begin
                            // left half takes the first point of this level
                            w_wr_ctl   = 1'b1;
                            w_ctl_addr = IW'(r_i);
                            w_ctl_data = (r_j == '0) ? r_acc : r_first;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov = 1'b1; n_od = r_acc; n_ost = ST_OK; n_olast = r_plast;
                end
            end
            S_TAIL_RD: begin
                w_rd_ctl = 1'b1; w_rd_addr = IW'(r_n - 1'b1);
            end
            S_TAIL_WR: begin
                // the new last point repeats the old last one
                w_wr_ctl = 1'b1; w_ctl_addr = IW'(r_n); w_ctl_data = r_rd;
                n_j = CW'(1);
                n_cnt = r_n + 1'b1;
            end
            S_COPY_RD: begin
                w_rd_addr = IW'(r_j);
            end
            S_COPY_WR: begin
                w_wr_ctl = 1'b1; w_ctl_addr = IW'(r_j); w_ctl_data = r_rd;
                n_j = r_j + 1'b1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov = 1'b1; n_od = '0; n_ost = r_pst; n_olast = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_ax <= n_ax; r_op <= n_op; r_t <= n_t;
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_first <= n_first;
        r_pst <= n_pst; r_plast <= n_plast; r_ret <= n_ret;
        r_od <= n_od; r_ost <= n_ost; r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tlast  = r_olast;

    // Point count never exceeds the store.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_POINTS) else $error("point count overflow");
    // No new item while the sequencer is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    // Error results carry zero coordinates.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result with data");

endmodule

>>> rtl/core/bce_alu.sv
// Shared per-axis arithmetic: either a rounded lerp p + round(t*(q-p)/65536) in one
// registered multiply, or a weighted mean (i*p + (n-i)*q)/n with a
// restoring divider that retires one quotient bit per cycle.
module bce_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bce_pkg::t_alu_req i_req,
    output logic              o_done,
    output bce_pkg::t_coord   o_res
);
    import bce_pkg::*;

    localparam int NumW = 41;

    logic                  r_busy, n_busy;
    logic                  r_div, n_div;
    logic                  r_neg, n_neg;
    logic [5:0]            r_cnt, n_cnt;
    logic [NumW-1:0]       r_quo, n_quo;
    logic [NumW-1:0]       r_rem, n_rem;
    logic [6:0]            r_den, n_den;
    logic signed [49:0]    r_prod, n_prod;
    t_coord                r_p, n_p;
    logic                  r_done, n_done;
    t_coord                r_res, n_res;

    logic signed [32:0]    w_diff;
    logic signed [NumW:0]  w_num;
    logic [NumW-1:0]       w_mag;
    logic [NumW:0]         w_trial;
    logic signed [50:0]    w_rnd;
    logic signed [NumW:0]  w_q;

    always_comb begin
        w_diff  = 33'(i_req.q) - 33'(i_req.p);
        w_num   = 42'(i_req.p) * $signed({35'd0, i_req.wi})
                + 42'(i_req.q) * $signed({35'd0, 7'(i_req.wn - i_req.wi)});
        w_mag   = w_num[NumW] ? 41'(-w_num) : w_num[NumW-1:0];
        w_trial = {r_rem, r_quo[NumW-1]} - {35'd0, r_den};
        w_rnd   = 51'(r_prod) + 51'sd32768;
        w_q     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    end

    // Sequence one operation.
    always_comb begin
        n_busy = r_busy; n_div = r_div; n_neg = r_neg; n_cnt = r_cnt;
        n_quo = r_quo; n_rem = r_rem; n_den = r_den; n_prod = r_prod;
        n_p = r_p; n_done = 1'b0; n_res = r_res;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_div  = i_req.is_div;
            n_p    = i_req.p;
            n_prod = 50'(w_diff) * $signed({1'b0, i_req.t});
            n_neg  = w_num[NumW];
            // add half the divisor before dividing: round half away
            n_quo  = w_mag + 41'(i_req.wn >> 1);
            n_rem  = '0;
            n_den  = i_req.wn;
            n_cnt  = 6'(NumW);
        end else if (r_busy && !r_div) begin
            n_busy = 1'b0;
            n_done = 1'b1;
            n_res  = 32'(r_p + 32'(w_rnd >>> 16));
        end else if (r_busy) begin
            if (r_cnt != 6'd0) begin
                if (!w_trial[NumW]) begin
                    n_rem = w_trial[NumW-1:0];
                    n_quo = {r_quo[NumW-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[NumW-2:0], r_quo[NumW-1]};
                    n_quo = {r_quo[NumW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_res  = 32'(w_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_div <= n_div; r_neg <= n_neg; r_cnt <= n_cnt; r_quo <= n_quo;
        r_rem <= n_rem; r_den <= n_den; r_prod <= n_prod; r_p <= n_p;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> bench/bezier_curve_engine_core_tb.sv
module bezier_curve_engine_core_tb;
    import bce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS       = 16;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t_status     status;
        logic        is_last;
    } t_curve_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [119:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    // Shadow copy of the curve store
    longint        curve_pts[NPTS][3];
    bit            slot_written[NPTS];
    int unsigned   point_total = 0;

    t_curve_result expected_points[$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            burst_left = 0;
    int            ready_left = 0;
    int            idle_cycles = 0;

    bezier_curve_engine_core #(.MAX_POINTS(NPTS)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Interpolate one axis: p + floor((q-p)*t/65536 + 1/2)
    function automatic longint lerp_axis(longint p, longint q, longint t);
        longint acc;
        acc = (q - p) * t + 32768;
        return p + (acc >>> 16);
    endfunction

    // Divide, rounding halves away from zero
    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic void push_result(longint pt[3], bit has_pt, t_status st, bit is_last);
        t_curve_result r;
        r.x = has_pt ? pt[0][31:0] : '0;
        r.y = has_pt ? pt[1][31:0] : '0;
        r.z = has_pt ? pt[2][31:0] : '0;
        r.status = st;
        r.is_last = is_last;
        expected_points.push_back(r);
    endfunction

    // Work out the results of one accepted item and update the shadow store
    function automatic void predict_item(t_op op, logic [3:0] idx, logic [31:0] cx,
                                         logic [31:0] cy, logic [31:0] cz,
                                         logic [15:0] t, logic fin);
        longint work[NPTS][3];
        longint none[3];
        int unsigned n;
        longint tt;
        n = point_total;
        tt = longint'(t);
        none = '{0, 0, 0};
        if (op == OP_LOAD) begin
            curve_pts[idx][0] = longint'(signed'(cx));
            curve_pts[idx][1] = longint'(signed'(cy));
            curve_pts[idx][2] = longint'(signed'(cz));
            slot_written[idx] = 1'b1;
            if (fin) point_total = idx + 1;
            return;
        end
        if (n == 0) begin
            push_result(none, 1'b0, ST_EMPTY, 1'b1);
            return;
        end
        case (op)
            OP_EVALUATE: begin
                work = curve_pts;
                for (int i = 1; i < n; i++)
                    for (int j = 0; j < n - i; j++)
                        for (int a = 0; a < 3; a++)
                            work[j][a] = lerp_axis(work[j][a], work[j+1][a], tt);
                push_result(work[0], 1'b1, ST_OK, 1'b1);
            end
            OP_SUBDIV: begin
                if (t == 0) begin
                    push_result(none, 1'b0, ST_BAD_T, 1'b1);
                end else begin
                    work = curve_pts;
                    push_result(curve_pts[n-1], 1'b1, ST_OK, n == 1);
                    for (int i = 1; i < n; i++) begin
                        for (int j = 0; j < n - i; j++)
                            for (int a = 0; a < 3; a++)
                                work[j][a] = lerp_axis(work[j][a], work[j+1][a], tt);
                        curve_pts[i] = work[0];
                        push_result(work[n-i-1], 1'b1, ST_OK, i == n - 1);
                    end
                end
            end
            default: begin
                if (n >= NPTS) begin
                    push_result(none, 1'b0, ST_FULL, 1'b1);
                end else begin
                    work[0] = curve_pts[0];
                    for (int i = 1; i < n; i++)
                        for (int a = 0; a < 3; a++)
                            work[i][a] = div_nearest(longint'(i) * curve_pts[i-1][a] +
                                longint'(n - i) * curve_pts[i][a], longint'(n));
                    work[n] = curve_pts[n-1];
                    for (int i = 0; i <= n; i++) curve_pts[i] = work[i];
                    slot_written[n] = 1'b1;
                    point_total = n + 1;
                    push_result(none, 1'b0, ST_OK, 1'b1);
                end
            end
        endcase
    endfunction

    // Send one item, honoring the burst and gap pattern
    task automatic send_item(t_op op, logic [3:0] idx, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [15:0] t, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= fin;
        s_axis_tdata  <= {4'b0, t, cz, cy, cx, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(op, idx, cx, cy, cz, t, fin);
        items_sent++;
    endtask

    // Hold off until every expected result has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_t();
        case ($urandom_range(0, 9))
            0: return 16'h0;
            1: return 16'hffff;
            2: return 16'h0001;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic bit curve_readable();
        for (int i = 0; i < point_total; i++)
            if (!slot_written[i]) return 0;
        return 1;
    endfunction

    // Load a full curve of k points, count set by the last one
    task automatic load_curve(int k);
        for (int i = 0; i < k; i++)
            send_item(OP_LOAD, i[3:0], rand_coord(), rand_coord(), rand_coord(),
                      16'($urandom_range(0, 16'hffff)), i == k - 1);
    endtask

    // Issue a curve operation, or fill a missing slot if the store is incomplete
    task automatic send_op(t_op op, logic [15:0] t);
        int gap_slot;
        gap_slot = 0;
        if (!curve_readable()) begin
            while (slot_written[gap_slot]) gap_slot++;
            send_item(OP_LOAD, gap_slot[3:0], rand_coord(), rand_coord(), rand_coord(),
                      t, 1'b0);
        end else begin
            send_item(op, 4'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                      rand_coord(), t, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_empty_curve();
        send_item(OP_EVALUATE, 4'hf, '1, '1, '1, 16'h8000, 1'b1);
        send_item(OP_SUBDIV, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_SUBDIV, 4'h5, '0, '0, '0, 16'h1234, 1'b0);
        send_item(OP_ELEVATE, 4'ha, '0, '0, '0, 16'hffff, 1'b1);
    endtask

    task automatic test_directed_ops();
        // single point curve
        send_item(OP_LOAD, 4'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'h0, 1'b1);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_SUBDIV, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_SUBDIV, 4'h0, '0, '0, '0, 16'h0001, 1'b0);
        // four points spanning the full range
        send_item(OP_LOAD, 4'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'hffff, 1'b0);
        send_item(OP_LOAD, 4'h1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h0, 1'b0);
        send_item(OP_LOAD, 4'h2, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 16'h0, 1'b0);
        send_item(OP_LOAD, 4'h3, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 16'h0, 1'b1);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'h8000, 1'b0);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'hffff, 1'b0);
        send_item(OP_SUBDIV, 4'h0, '0, '0, '0, 16'h8000, 1'b0);
        send_item(OP_ELEVATE, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'h5555, 1'b0);
        wait_drain();
    endtask

    task automatic test_full_store();
        load_curve(NPTS);
        send_item(OP_ELEVATE, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'hffff, 1'b0);
        send_item(OP_SUBDIV, 4'h0, '0, '0, '0, 16'hffff, 1'b0);
        // grow a short curve by elevation up to full
        load_curve(13);
        repeat (4) send_item(OP_ELEVATE, 4'h0, '0, '0, '0, 16'h0, 1'b0);
        send_item(OP_EVALUATE, 4'h0, '0, '0, '0, 16'h0001, 1'b0);
    endtask

    task automatic test_random_traffic();
        int k;
        while (items_sent < 320) begin
            if ($urandom_range(0, 4) != 0) begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, NPTS)
                                                : $urandom_range(1, 6);
                load_curve(k);
                repeat ($urandom_range(1, 4))
                    send_op(t_op'($urandom_range(1, 3)), rand_t());
            end else if ($urandom_range(0, 1) == 0) begin
                // stray load, possibly a broken sequence
                send_item(OP_LOAD, 4'($urandom_range(0, 15)), rand_coord(), rand_coord(),
                          rand_coord(), rand_t(), 1'($urandom_range(0, 1)));
            end else begin
                send_op(t_op'($urandom_range(0, 3)), rand_t());
            end
            if ($urandom_range(0, 19) == 0) wait_drain();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver: ready stretches and stalls of random length
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(1, 8);
            end else begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(1, 40);
            end
        end else begin
            ready_left--;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_curve_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: data=%h status=%0d last=%0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                exp_r = expected_points.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.x || m_axis_tdata[63:32] !== exp_r.y ||
                    m_axis_tdata[95:64] !== exp_r.z || m_axis_tuser !== exp_r.status ||
                    m_axis_tlast !== exp_r.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h st=%0d last=%0b, got x=%h y=%h z=%h st=%0d last=%0b",
                                 exp_r.x, exp_r.y, exp_r.z, exp_r.status, exp_r.is_last,
                                 m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[95:64], m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NPTS; i++) slot_written[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_curve();
        test_directed_ops();
        test_full_store();
        test_random_traffic();
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bce_pkg.sv
rtl/core/bce_alu.sv
rtl/core/bezier_curve_engine_core.sv
bench/bezier_curve_engine_core_tb.sv
